FILE: hdl/sars_pkg.sv
// shared types and constants for the sorted array range search block
package sars_pkg;

  localparam int SARS_DEPTH = 1024;
  localparam int VALUE_W    = 32;
  localparam int IDX_W      = 11;
  localparam int OP_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOWER,
    S_UPPER,
    S_DONE
  } state_t;

endpackage

FILE: hdl/sars_if.sv
// request and response channel interfaces
interface sars_req_if import sars_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface sars_rsp_if import sars_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [IDX_W-1:0] first_index;
  logic signed [IDX_W-1:0] last_index;

  modport source (output valid, output first_index, output last_index, input ready);
  modport sink   (input valid, input first_index, input last_index, output ready);
endinterface

FILE: hdl/sorted_array_range_search_top.sv
// top level of the sorted array range search block
// append and clear: no response, the next request can be accepted the cycle after
// search: one memory probe per cycle, lower bound then upper bound bisection,
//   each probe using the single read port of the element memory
// reset clears the element count and the control state, memory contents stay undefined
module sorted_array_range_search_top import sars_pkg::*; #(
  parameter int DEPTH = SARS_DEPTH
) (
  input logic        clk,
  input logic        rst,
  sars_req_if.sink   req,
  sars_rsp_if.source rsp
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // control registers
  state_t                    state, state_next;
  logic [CNT_W-1:0]          count, count_next;
  logic                      rsp_valid, rsp_valid_next;

  // search datapath registers
  logic [CNT_W-1:0]          lo, lo_next;
  logic [CNT_W-1:0]          hi, hi_next;
  logic [CNT_W-1:0]          lb, lb_next;
  logic                      pend, pend_next;
  logic                      found_first, found_first_next;
  logic                      found_last, found_last_next;
  logic signed [VALUE_W-1:0] key, key_next;
  logic [AW-1:0]             rd_addr_q;
  logic signed [IDX_W-1:0]   first_q, first_next;
  logic signed [IDX_W-1:0]   last_q, last_next;

  // memory port signals
  logic                      we;
  logic [AW-1:0]             waddr;
  logic                      re;
  logic [AW-1:0]             raddr;
  logic signed [VALUE_W-1:0] rdata;

  // per-probe combinational values
  logic                      upper;
  logic                      go_right;
  logic                      hit;
  logic [CNT_W-1:0]          lo_eff, hi_eff;
  logic [CNT_W-1:0]          span;
  logic                      accept;

  sars_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (req.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req.ready       = (state == S_IDLE);
  assign accept          = req.valid && req.ready;
  assign rsp.valid       = rsp_valid;
  assign rsp.first_index = first_q;
  assign rsp.last_index  = last_q;

  // appends write straight at the fill position, only while idle
  assign we    = accept && (req.op == OP_APPEND) && (count < CNT_W'(DEPTH));
  assign waddr = count[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
      pend      <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    lo          <= lo_next;
    hi          <= hi_next;
    lb          <= lb_next;
    found_first <= found_first_next;
    found_last  <= found_last_next;
    key         <= key_next;
    first_q     <= first_next;
    last_q      <= last_next;
    if (re) begin
      rd_addr_q <= raddr;
    end
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    rsp_valid_next   = rsp_valid && !rsp.ready;
    lo_next          = lo;
    hi_next          = hi;
    lb_next          = lb;
    pend_next        = 1'b0;
    found_first_next = found_first;
    found_last_next  = found_last;
    key_next         = key;
    first_next       = first_q;
    last_next        = last_q;
    re               = 1'b0;
    raddr            = '0;

    // resolve the probe whose data arrives this cycle
    upper    = (state == S_UPPER);
    go_right = upper ? (rdata <= key) : (rdata < key);
    hit      = (rdata == key);
    lo_eff   = lo;
    hi_eff   = hi;
    if (pend) begin
      if (go_right) begin
        lo_eff = CNT_W'(rd_addr_q) + CNT_W'(1);
      end else begin
        hi_eff = CNT_W'(rd_addr_q);
      end
    end
    span = hi_eff - lo_eff;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.op)
            OP_APPEND: begin
              if (count < CNT_W'(DEPTH)) begin
                count_next = count + CNT_W'(1);
              end
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_SEARCH: begin
              key_next         = req.value;
              lo_next          = '0;
              hi_next          = count;
              found_first_next = 1'b0;
              found_last_next  = 1'b0;
              state_next       = S_LOWER;
            end
            default: begin
              // unused op code, dropped
            end
          endcase
        end
      end

      S_LOWER, S_UPPER: begin
        // the last probe that moved the bound carries the equality check
        if (pend && !upper && !go_right) begin
          found_first_next = hit;
        end
        if (pend && upper && go_right) begin
          found_last_next = hit;
        end
        lo_next = lo_eff;
        hi_next = hi_eff;
        if (lo_eff < hi_eff) begin
          re        = 1'b1;
          raddr     = AW'(lo_eff + (span >> 1));
          pend_next = 1'b1;
        end else if (!upper) begin
          lb_next    = lo_eff;
          lo_next    = '0;
          hi_next    = count;
          state_next = S_UPPER;
        end else begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        // lo holds the upper bound here
        if (!rsp_valid || rsp.ready) begin
          first_next     = found_first ? IDX_W'(lb) : '1;
          last_next      = found_last ? IDX_W'(lo - CNT_W'(1)) : '1;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // fill level never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("element count above capacity");

  // search window stays ordered while bisecting
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOWER || state == S_UPPER) |-> lo <= hi)
    else $error("search window inverted");

  // an accepted search starts the lower bound pass
  a_search_start: assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == OP_SEARCH) |=> (state == S_LOWER && !pend))
    else $error("search did not start");

  // finishing a search always presents a response
  a_done_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && state_next == S_IDLE) |=> rsp_valid)
    else $error("search finished without response");

  // a last occurrence implies a nonzero upper bound
  a_last_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && found_last) |-> lo != '0)
    else $error("last occurrence with empty upper bound");

  // no memory write while a search is in flight
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !we)
    else $error("write during search");

endmodule

FILE: hdl/sars_mem.sv
// element memory: one write port, one read port with registered read data
module sars_mem import sars_pkg::*; #(
  parameter int DEPTH = SARS_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic signed [VALUE_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic signed [VALUE_W-1:0] rdata
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
